FILE: rtl/ptb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic timer bank package
// Shared widths, command codes, controller states and the command and status
// bundles exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package ptb_pkg;

	localparam int CMD_W    = 2;
	localparam int ID_W     = 4;
	localparam int DELAY_W  = 32;
	localparam int PERIOD_W = 32;
	localparam int TIME_W   = 48;
	localparam int WAIT_W   = 16;

	localparam logic [WAIT_W-1:0] MAX_WAIT_RESET = 16'd1000;

	localparam logic KIND_EXPIRY  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 2'd0,
		CMD_START   = 2'd1,
		CMD_STOP    = 2'd2,
		CMD_TRIGGER = 2'd3
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL,
		ST_MOD,
		ST_DIV,
		ST_ADV,
		ST_FIRE,
		ST_SUM
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic apply;
		logic tick;
		logic idx_clr;
		logic idx_inc;
		logic eval;
		logic disarm;
		logic mod_start;
		logic adv;
		logic load_fire;
		logic load_sum;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic armed_cur;
		logic due;
		logic periodic;
		logic idx_last;
		logic mod_busy;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

FILE: rtl/ptb_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic timer bank request channel
// Valid/ready channel that carries one timer command per request.
// ----------------------------------------------------------------------------
interface ptb_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [ptb_pkg::CMD_W-1:0]      cmd;
	logic [ptb_pkg::ID_W-1:0]       timer_id;
	logic [ptb_pkg::DELAY_W-1:0]    delay_ms;
	logic [ptb_pkg::PERIOD_W-1:0]   period_ms;

	modport source (output valid, cmd, timer_id, delay_ms, period_ms, input ready);
	modport sink (input valid, cmd, timer_id, delay_ms, period_ms, output ready);
endinterface
`default_nettype wire

FILE: rtl/ptb_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic timer bank result channel
// Valid/ready channel that carries expiry reports and the per-tick summary.
// ----------------------------------------------------------------------------
interface ptb_res_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [ptb_pkg::ID_W-1:0]     fired_id;
	logic [ptb_pkg::WAIT_W-1:0]   next_ms;
	logic                         last;

	modport source (output valid, kind, fired_id, next_ms, last, input ready);
	modport sink (input valid, kind, fired_id, next_ms, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/ptb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic timer bank RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ptb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/ptb_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic timer bank remainder unit
// Restoring bit-serial remainder of a time difference by a timer period,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ptb_mod (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [ptb_pkg::TIME_W-1:0]     dividend,
	input  wire logic [ptb_pkg::PERIOD_W-1:0]   divisor,
	output      logic                           busy,
	output      logic [ptb_pkg::PERIOD_W-1:0]   rem
);

	localparam int STEPS = ptb_pkg::TIME_W;
	localparam int CW    = $clog2(STEPS + 1);
	localparam int PW    = ptb_pkg::PERIOD_W;

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [STEPS-1:0] dvd_q;
	logic [PW-1:0] rem_q;
	logic [PW:0]   trial;
	logic [PW:0]   trial_sub;
	logic [PW-1:0] rem_next;

	assign trial     = {rem_q, dvd_q[STEPS-1]};
	assign trial_sub = trial - {1'b0, divisor};

	always_comb begin
		if (trial >= {1'b0, divisor}) begin
			rem_next = trial_sub[PW-1:0];
		end else begin
			rem_next = trial[PW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[STEPS-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

	// A finished remainder is always reduced below the period.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> (rem_q < divisor))
		else $error("remainder not reduced below divisor");

endmodule
`default_nettype wire

FILE: rtl/ptb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic timer bank datapath
// Time base, deadline and period memories, armed bits, scan index, wait
// minimum, remainder unit and the result output register.
// ----------------------------------------------------------------------------
module ptb_dp #(
	parameter int NUM_TIMERS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire ptb_pkg::ctl_t                  ctl,
	output      ptb_pkg::sts_t                  sts,
	input  wire logic [ptb_pkg::CMD_W-1:0]      cmd,
	input  wire logic [ptb_pkg::ID_W-1:0]       timer_id,
	input  wire logic [ptb_pkg::DELAY_W-1:0]    delay_ms,
	input  wire logic [ptb_pkg::PERIOD_W-1:0]   period_ms,
	input  wire logic                           cfg_we,
	input  wire logic [ptb_pkg::WAIT_W-1:0]     cfg_wdata,
	input  wire logic                           res_ready,
	output      logic                           res_valid,
	output      logic                           kind,
	output      logic [ptb_pkg::ID_W-1:0]       fired_id,
	output      logic [ptb_pkg::WAIT_W-1:0]     next_ms,
	output      logic                           last
);

	localparam int AW = $clog2(NUM_TIMERS);
	localparam int TW = ptb_pkg::TIME_W;
	localparam int PW = ptb_pkg::PERIOD_W;
	localparam int WW = ptb_pkg::WAIT_W;

	logic [TW-1:0]         now_q;
	logic [WW-1:0]         max_wait_q;
	logic [WW-1:0]         wait_q;
	logic [NUM_TIMERS-1:0] armed_q;
	logic [AW-1:0]         idx_q;
	logic                  res_valid_q;

	logic [TW-1:0] diff_q;
	logic          diff_zero_q;
	logic [PW-1:0] p_q;
	logic [PW-1:0] off_q;
	logic          kind_q;
	logic [ptb_pkg::ID_W-1:0] fired_q;
	logic [WW-1:0] next_q;
	logic          last_q;

	logic [AW-1:0] cmd_addr;
	logic          id_ok;
	logic          dl_we;
	logic [AW-1:0] dl_waddr;
	logic [TW-1:0] dl_wdata;
	logic [TW-1:0] dl_rdata;
	logic          pr_we;
	logic [PW-1:0] pr_rdata;

	logic [TW:0]   ahead;
	logic [TW-1:0] behind;
	logic          not_due;
	logic          near_ahead;
	logic [PW-1:0] rem;
	logic          mod_busy;
	logic [PW-1:0] off_d;
	logic [TW:0]   adv_sum;
	logic          near_off;
	logic          out_free;

	assign cmd_addr = AW'(timer_id);
	assign id_ok    = 32'(timer_id) < 32'(NUM_TIMERS);

	// Deadline write port serves start and trigger when idle and the periodic
	// advance during a scan.
	always_comb begin
		dl_we    = 1'b0;
		dl_waddr = idx_q;
		dl_wdata = adv_sum[TW-1:0];
		pr_we    = 1'b0;
		if (ctl.apply && id_ok) begin
			case (ptb_pkg::cmd_code_t'(cmd))
				ptb_pkg::CMD_START: begin
					dl_we    = 1'b1;
					dl_waddr = cmd_addr;
					dl_wdata = now_q + TW'(delay_ms);
					pr_we    = 1'b1;
				end
				ptb_pkg::CMD_TRIGGER: begin
					dl_we    = armed_q[cmd_addr];
					dl_waddr = cmd_addr;
					dl_wdata = now_q;
				end
				default: begin
					dl_we = 1'b0;
				end
			endcase
		end else if (ctl.adv) begin
			dl_we = 1'b1;
		end
	end

	ptb_ram #(.WIDTH(TW), .DEPTH(NUM_TIMERS)) u_dl_ram (
		.clk   (clk),
		.we    (dl_we),
		.waddr (dl_waddr),
		.wdata (dl_wdata),
		.raddr (idx_q),
		.rdata (dl_rdata)
	);

	ptb_ram #(.WIDTH(PW), .DEPTH(NUM_TIMERS)) u_pr_ram (
		.clk   (clk),
		.we    (pr_we),
		.waddr (cmd_addr),
		.wdata (period_ms),
		.raddr (idx_q),
		.rdata (pr_rdata)
	);

	ptb_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.mod_start),
		.dividend (diff_q),
		.divisor  (p_q),
		.busy     (mod_busy),
		.rem      (rem)
	);

	// A deadline is due when it is not after the current time.
	assign ahead      = {1'b0, dl_rdata} - {1'b0, now_q};
	assign behind     = now_q - dl_rdata;
	assign not_due    = !ahead[TW] && (ahead[TW-1:0] != '0);
	assign near_ahead = (ahead[TW-1:WW] == '0) && (ahead[WW-1:0] < wait_q);

	// Offset of the advanced deadline from now: a full period when the timer
	// is exactly due, otherwise up to the next period boundary.
	always_comb begin
		if (diff_zero_q) begin
			off_d = p_q;
		end else if (rem == '0) begin
			off_d = '0;
		end else begin
			off_d = p_q - rem;
		end
	end

	// A carry out means the new deadline wrapped below now and is ignored
	// for the wait.
	assign adv_sum  = {1'b0, now_q} + (TW + 1)'(off_q);
	assign near_off = !adv_sum[TW] && (off_q[PW-1:WW] == '0) && (off_q[WW-1:0] < wait_q);

	assign out_free = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			max_wait_q  <= ptb_pkg::MAX_WAIT_RESET;
			wait_q      <= '0;
			armed_q     <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_wait_q <= cfg_wdata;
			end
			if (ctl.tick) begin
				now_q  <= now_q + 1'b1;
				wait_q <= max_wait_q;
			end else if (ctl.eval && not_due && near_ahead) begin
				wait_q <= ahead[WW-1:0];
			end else if (ctl.adv && near_off) begin
				wait_q <= off_q[WW-1:0];
			end
			if (ctl.apply && id_ok) begin
				if (cmd == ptb_pkg::CMD_START) begin
					armed_q[cmd_addr] <= 1'b1;
				end else if (cmd == ptb_pkg::CMD_STOP) begin
					armed_q[cmd_addr] <= 1'b0;
				end
			end else if (ctl.disarm) begin
				armed_q[idx_q] <= 1'b0;
			end
			if (ctl.idx_clr) begin
				idx_q <= '0;
			end else if (ctl.idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (ctl.load_fire || ctl.load_sum) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			diff_q      <= behind;
			diff_zero_q <= (dl_rdata == now_q);
			p_q         <= pr_rdata;
		end
		off_q <= off_d;
		if (ctl.load_fire) begin
			kind_q  <= ptb_pkg::KIND_EXPIRY;
			fired_q <= ptb_pkg::ID_W'(idx_q);
			next_q  <= '0;
			last_q  <= 1'b0;
		end else if (ctl.load_sum) begin
			kind_q  <= ptb_pkg::KIND_SUMMARY;
			fired_q <= '0;
			next_q  <= wait_q;
			last_q  <= 1'b1;
		end
	end

	assign sts.armed_cur = armed_q[idx_q];
	assign sts.due       = !not_due;
	assign sts.periodic  = (pr_rdata != '0);
	assign sts.idx_last  = (idx_q == AW'(NUM_TIMERS - 1));
	assign sts.mod_busy  = mod_busy;
	assign sts.out_free  = out_free;

	assign res_valid = res_valid_q;
	assign kind      = kind_q;
	assign fired_id  = fired_q;
	assign next_ms   = next_q;
	assign last      = last_q;

	// A result is loaded only into a free output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.load_fire || ctl.load_sum) |-> out_free)
		else $error("result loaded over a pending result");

	// Only periodic timers reach the deadline advance.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.adv |-> (p_q != '0))
		else $error("deadline advance with zero period");

endmodule
`default_nettype wire

FILE: rtl/ptb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic timer bank controller
// Accepts requests, sequences the per-timer scan of a tick and emits the
// expiry reports and the closing summary.
// ----------------------------------------------------------------------------
module ptb_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	input  wire logic [ptb_pkg::CMD_W-1:0]  req_cmd,
	output      logic                       req_ready,
	input  wire ptb_pkg::sts_t              sts,
	output      ptb_pkg::ctl_t              ctl
);

	ptb_pkg::state_t state_q;
	ptb_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		req_ready = 1'b0;
		case (state_q)
			ptb_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (req_cmd == ptb_pkg::CMD_TICK) begin
						ctl.tick    = 1'b1;
						ctl.idx_clr = 1'b1;
						state_d     = ptb_pkg::ST_SCAN;
					end else begin
						ctl.apply = 1'b1;
					end
				end
			end
			ptb_pkg::ST_SCAN: begin
				if (sts.armed_cur) begin
					state_d = ptb_pkg::ST_EVAL;
				end else if (sts.idx_last) begin
					state_d = ptb_pkg::ST_SUM;
				end else begin
					ctl.idx_inc = 1'b1;
				end
			end
			ptb_pkg::ST_EVAL: begin
				ctl.eval = 1'b1;
				if (!sts.due) begin
					if (sts.idx_last) begin
						state_d = ptb_pkg::ST_SUM;
					end else begin
						ctl.idx_inc = 1'b1;
						state_d     = ptb_pkg::ST_SCAN;
					end
				end else if (sts.periodic) begin
					state_d = ptb_pkg::ST_MOD;
				end else begin
					ctl.disarm = 1'b1;
					state_d    = ptb_pkg::ST_FIRE;
				end
			end
			ptb_pkg::ST_MOD: begin
				ctl.mod_start = 1'b1;
				state_d       = ptb_pkg::ST_DIV;
			end
			ptb_pkg::ST_DIV: begin
				if (!sts.mod_busy) begin
					state_d = ptb_pkg::ST_ADV;
				end
			end
			ptb_pkg::ST_ADV: begin
				ctl.adv = 1'b1;
				state_d = ptb_pkg::ST_FIRE;
			end
			ptb_pkg::ST_FIRE: begin
				if (sts.out_free) begin
					ctl.load_fire = 1'b1;
					if (sts.idx_last) begin
						state_d = ptb_pkg::ST_SUM;
					end else begin
						ctl.idx_inc = 1'b1;
						state_d     = ptb_pkg::ST_SCAN;
					end
				end
			end
			ptb_pkg::ST_SUM: begin
				if (sts.out_free) begin
					ctl.load_sum = 1'b1;
					state_d      = ptb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ptb_pkg::ST_IDLE;
			end
		endcase
	end

	// Evaluation only ever looks at a timer that is armed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptb_pkg::ST_EVAL) |-> sts.armed_cur)
		else $error("evaluating a disarmed timer");

	// The advance uses a finished remainder straight after the wait.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptb_pkg::ST_ADV) |->
			(!sts.mod_busy && ($past(state_q) == ptb_pkg::ST_DIV)))
		else $error("advance without finished remainder");

endmodule
`default_nettype wire

FILE: rtl/periodic_timer_bank_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic timer bank
// A bank of NUM_TIMERS millisecond timers with one-shot and periodic modes.
// ----------------------------------------------------------------------------
// Start, stop and trigger requests give no result. A tick advances the time
// base and scans the timers one at a time, giving one expiry report per due
// timer and then a summary with the capped wait until the nearest deadline.
// Each expiring periodic timer passes through the 48-step bit-serial remainder
// unit that finds the next period boundary, and the scan waits while the
// result channel holds back.
// Deadlines and periods live in two RAMs read one timer per cycle.
module periodic_timer_bank_unit #(
	parameter int NUM_TIMERS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	ptb_cmd_if.sink                          cmd_ch,
	ptb_res_if.source                        res_ch,
	input  wire logic                        cfg_we,
	input  wire logic [ptb_pkg::WAIT_W-1:0]  cfg_wdata
);

	ptb_pkg::ctl_t ctl;
	ptb_pkg::sts_t sts;

	ptb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (cmd_ch.valid),
		.req_cmd   (cmd_ch.cmd),
		.req_ready (cmd_ch.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	ptb_dp #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cmd       (cmd_ch.cmd),
		.timer_id  (cmd_ch.timer_id),
		.delay_ms  (cmd_ch.delay_ms),
		.period_ms (cmd_ch.period_ms),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res_ready (res_ch.ready),
		.res_valid (res_ch.valid),
		.kind      (res_ch.kind),
		.fired_id  (res_ch.fired_id),
		.next_ms   (res_ch.next_ms),
		.last      (res_ch.last)
	);

endmodule
`default_nettype wire

FILE: tb/ptb_expiry_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic timer bank expiry checker
// Watches the request, result and register ports of the timer bank, keeps its
// own copy of the time base and the timers, and compares every result against
// the expiry reports and tick summaries that the accepted requests call for.
// ----------------------------------------------------------------------------
module ptb_expiry_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	ptb_cmd_if                          cmd_ch,
	ptb_res_if                          res_ch,
	input  logic                        cfg_we,
	input  logic [ptb_pkg::WAIT_W-1:0]  cfg_wdata,
	output int                          mismatch_count,
	output int                          pending_reports
);
	import ptb_pkg::*;

	localparam int TIMER_COUNT = 16;

	typedef struct packed {
		logic              kind;
		logic [ID_W-1:0]   fired_id;
		logic [WAIT_W-1:0] next_ms;
		logic              last;
	} timer_report_t;

	logic [TIME_W-1:0]   now_ms;
	logic [TIME_W-1:0]   due_at [TIMER_COUNT];
	logic [PERIOD_W-1:0] repeat_ms [TIMER_COUNT];
	logic                live [TIMER_COUNT];
	logic [WAIT_W-1:0]   wait_cap;

	timer_report_t expected_reports[$];

	task automatic report_mismatch(string msg);
		$display("%0t ns: timer bank mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// Earliest deadline a whole number of periods (at least one) past dl that is
	// not before the current time.
	function automatic logic [TIME_W-1:0] next_boundary(logic [TIME_W-1:0] dl,
			logic [PERIOD_W-1:0] p);
		logic [TIME_W-1:0] lag;
		logic [TIME_W-1:0] rem;
		lag = now_ms - dl;
		if (lag == 0)
			return now_ms + p;
		rem = lag % p;
		if (rem == 0)
			return now_ms;
		return now_ms + (p - rem);
	endfunction

	task automatic apply_timer_request(cmd_code_t code, logic [ID_W-1:0] id,
			logic [DELAY_W-1:0] delay, logic [PERIOD_W-1:0] per);
		logic [63:0]   gap;
		logic [63:0]   wait_ms;
		timer_report_t rpt;
		case (code)
			CMD_START: begin
				due_at[id] = now_ms + delay;
				repeat_ms[id] = per;
				live[id] = 1'b1;
			end
			CMD_STOP: begin
				due_at[id] = '0;
				repeat_ms[id] = '0;
				live[id] = 1'b0;
			end
			CMD_TRIGGER: begin
				if (live[id])
					due_at[id] = now_ms;
			end
			default: begin
				now_ms = now_ms + 1'b1;
				wait_ms = wait_cap;
				for (int i = 0; i < TIMER_COUNT; i++) begin
					if (!live[i])
						continue;
					if (due_at[i] > now_ms) begin
						gap = due_at[i] - now_ms;
						if (gap < wait_ms)
							wait_ms = gap;
						continue;
					end
					if (repeat_ms[i] == 0) begin
						live[i] = 1'b0;
						due_at[i] = '0;
					end else begin
						due_at[i] = next_boundary(due_at[i], repeat_ms[i]);
						// A wrapped deadline gives a huge gap here, as it should.
						gap = {16'd0, due_at[i]} - {16'd0, now_ms};
						if (gap < wait_ms)
							wait_ms = gap;
					end
					rpt.kind = KIND_EXPIRY;
					rpt.fired_id = ID_W'(i);
					rpt.next_ms = '0;
					rpt.last = 1'b0;
					expected_reports.push_back(rpt);
				end
				rpt.kind = KIND_SUMMARY;
				rpt.fired_id = '0;
				rpt.next_ms = wait_ms[WAIT_W-1:0];
				rpt.last = 1'b1;
				expected_reports.push_back(rpt);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		timer_report_t seen;
		timer_report_t want;
		if (!arst_n) begin
			now_ms = '0;
			for (int i = 0; i < TIMER_COUNT; i++) begin
				due_at[i] = '0;
				repeat_ms[i] = '0;
				live[i] = 1'b0;
			end
			wait_cap = MAX_WAIT_RESET;
			expected_reports.delete();
			mismatch_count = 0;
			pending_reports <= 0;
		end else begin
			if (cfg_we)
				wait_cap = cfg_wdata;
			if (cmd_ch.valid && cmd_ch.ready)
				apply_timer_request(cmd_code_t'(cmd_ch.cmd), cmd_ch.timer_id,
					cmd_ch.delay_ms, cmd_ch.period_ms);
			if (res_ch.valid && res_ch.ready) begin
				seen.kind = res_ch.kind;
				seen.fired_id = res_ch.fired_id;
				seen.next_ms = res_ch.next_ms;
				seen.last = res_ch.last;
				if (expected_reports.size() == 0) begin
					report_mismatch($sformatf("unexpected result kind %0d id %0d wait %0d last %0d",
						seen.kind, seen.fired_id, seen.next_ms, seen.last));
				end else begin
					want = expected_reports.pop_front();
					if (seen !== want)
						report_mismatch($sformatf(
							"got kind %0d id %0d wait %0d last %0d, want %0d %0d %0d %0d",
							seen.kind, seen.fired_id, seen.next_ms, seen.last,
							want.kind, want.fired_id, want.next_ms, want.last));
				end
			end
			pending_reports <= expected_reports.size();
		end
	end

endmodule

FILE: tb/tb_periodic_timer_bank_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic timer bank testbench
// Drives directed and random timer requests under random flow control, moves
// the wait cap through its extremes between phases, and reports the verdict
// from the mismatch count and the pending report count of the expiry checker.
// ----------------------------------------------------------------------------
module tb_periodic_timer_bank_unit;
	import ptb_pkg::*;

	localparam int HOLD_OFF_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [WAIT_W-1:0] cfg_wdata;
	int mismatch_count;
	int pending_reports;
	logic steady;
	logic hold_go;
	logic held_done;

	ptb_cmd_if cmd_ch();
	ptb_res_if res_ch();

	periodic_timer_bank_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ch    (cmd_ch),
		.res_ch    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	ptb_expiry_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_ch          (cmd_ch),
		.res_ch          (res_ch),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.mismatch_count  (mismatch_count),
		.pending_reports (pending_reports)
	);

	always #10 clk = ~clk;

	initial begin
		#60_000_000;
		$display("tb_periodic_timer_bank_unit failed");
		$finish;
	end

	// Result side: random back-pressure, plus one long hold-off on request.
	initial begin
		res_ch.ready = 1'b0;
		held_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !held_done) begin
				held_done = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			res_ch.ready <= steady || ($urandom_range(99) >= 27);
		end
	end

	task automatic send_req(cmd_code_t code, logic [ID_W-1:0] id,
			logic [DELAY_W-1:0] delay, logic [PERIOD_W-1:0] per);
		while (!steady && $urandom_range(99) < 27) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.cmd <= code;
		cmd_ch.timer_id <= id;
		cmd_ch.delay_ms <= delay;
		cmd_ch.period_ms <= per;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	// Stop sending until every expected result is back, then give a start, stop
	// or trigger still in flight time to land.
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_reports != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic write_cap(logic [WAIT_W-1:0] value);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [DELAY_W-1:0] pick_delay();
		case ($urandom_range(9))
			7: return $urandom_range(3000, 13);
			8, 9: return $urandom;
			default: return $urandom_range(12, 0);
		endcase
	endfunction

	function automatic logic [PERIOD_W-1:0] pick_period();
		case ($urandom_range(9))
			0, 1, 2, 3: return '0;
			8: return $urandom_range(500, 7);
			9: return $urandom;
			default: return $urandom_range(6, 1);
		endcase
	endfunction

	// Mostly ticks and starts so that timers keep expiring; now and then every
	// timer is armed at once so that one tick reports all of them.
	task automatic run_mix(int count);
		int sel;
		int sent;
		sent = 0;
		while (sent < count) begin
			sel = $urandom_range(99);
			if (sel < 6) begin
				for (int i = 0; i < 16; i++)
					send_req(CMD_START, ID_W'(i), $urandom_range(1, 0), pick_period());
				send_req(CMD_TICK, $urandom, $urandom, $urandom);
				sent += 17;
			end else begin
				if (sel < 50)
					send_req(CMD_TICK, $urandom, $urandom, $urandom);
				else if (sel < 78)
					send_req(CMD_START, $urandom, pick_delay(), pick_period());
				else if (sel < 88)
					send_req(CMD_STOP, $urandom, $urandom, $urandom);
				else
					send_req(CMD_TRIGGER, $urandom, $urandom, $urandom);
				sent++;
			end
		end
	endtask

	initial begin
		logic [WAIT_W-1:0] caps [5];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		steady = 1'b0;
		hold_go = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd = CMD_TICK;
		cmd_ch.timer_id = '0;
		cmd_ch.delay_ms = '0;
		cmd_ch.period_ms = '0;
		caps[0] = 16'd1;
		caps[1] = 16'hFFFF;
		caps[2] = 16'd0;
		caps[3] = $urandom_range(999, 2);
		caps[4] = MAX_WAIT_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset wait cap.
		send_req(CMD_START, 4'd0, 32'd0, 32'd0);
		send_req(CMD_START, 4'd15, 32'd3, 32'd2);
		send_req(CMD_START, 4'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_req(CMD_TRIGGER, 4'd2, 32'd0, 32'd0);
		send_req(CMD_TRIGGER, 4'd1, 32'd0, 32'd0);
		send_req(CMD_TICK, 4'd0, 32'd0, 32'd0);
		send_req(CMD_START, 4'd15, 32'd1, 32'd5);
		send_req(CMD_START, 4'd3, 32'd0, 32'd1);
		send_req(CMD_TICK, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_req(CMD_TICK, 4'd0, 32'd0, 32'd0);
		send_req(CMD_TICK, 4'd0, 32'd0, 32'd0);
		send_req(CMD_TRIGGER, 4'd3, 32'd0, 32'd0);
		send_req(CMD_TICK, 4'd0, 32'd0, 32'd0);
		send_req(CMD_STOP, 4'd15, 32'd0, 32'd0);
		send_req(CMD_STOP, 4'd7, 32'd0, 32'd0);
		send_req(CMD_TICK, 4'd0, 32'd0, 32'd0);
		send_req(CMD_START, 4'd14, 32'd2, 32'd0);
		send_req(CMD_TICK, 4'd0, 32'd0, 32'd0);
		send_req(CMD_TICK, 4'd0, 32'd0, 32'd0);
		send_req(CMD_TICK, 4'd0, 32'd0, 32'd0);
		send_req(CMD_STOP, 4'd3, 32'd0, 32'd0);
		send_req(CMD_STOP, 4'd1, 32'd0, 32'd0);
		send_req(CMD_START, 4'd8, 32'hFFFF_FFFF, 32'd0);
		send_req(CMD_TICK, 4'd0, 32'd0, 32'd0);
		send_req(CMD_TICK, 4'd0, 32'd0, 32'd0);

		for (int phase = 0; phase < 5; phase++) begin
			settle();
			write_cap(caps[phase]);
			steady <= (phase == 2);
			if (phase == 3)
				hold_go <= 1'b1;
			run_mix(72);
		end
		settle();
		repeat (100) @(posedge clk);

		if (mismatch_count == 0 && pending_reports == 0)
			$display("tb_periodic_timer_bank_unit passed");
		else
			$display("tb_periodic_timer_bank_unit failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/ptb_pkg.sv
rtl/ptb_cmd_if.sv
rtl/ptb_res_if.sv
rtl/ptb_ram.sv
rtl/ptb_mod.sv
rtl/ptb_dp.sv
rtl/ptb_ctrl.sv
rtl/periodic_timer_bank_unit.sv
tb/ptb_expiry_checker.sv
tb/tb_periodic_timer_bank_unit.sv
